>>> hdl/gf2_poly_basis_convert_256_top_assert.svh
`ifndef GF2_POLY_BASIS_CONVERT_256_TOP_ASSERT_SVH
`define GF2_POLY_BASIS_CONVERT_256_TOP_ASSERT_SVH

// Same-cycle implication, checked only out of reset
`define GPBC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset
`define GPBC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gpbc_pkg.sv
package gpbc_pkg;

  typedef logic [63:0] word_t;
  typedef logic [3:0][63:0] blk_t;
  typedef logic [7:0] tab16_t [16];

  typedef enum logic {
    MODE_FWD = 1'b0,
    MODE_INV = 1'b1
  } mode_t;

  // Carry-less multiplier of the byte step
  localparam logic [7:0] CLMUL_K = 8'h16;

  localparam tab16_t FWD_HI_TAB = '{8'h00, 8'h02, 8'h04, 8'h06, 8'h28, 8'h2a, 8'h2c, 8'h2e,
                                    8'h72, 8'h70, 8'h76, 8'h74, 8'h5a, 8'h58, 8'h5e, 8'h5c};
  localparam tab16_t FWD_LO_TAB = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h02, 8'h02, 8'h02,
                                    8'h06, 8'h06, 8'h06, 8'h06, 8'h04, 8'h04, 8'h04, 8'h04};
  localparam tab16_t INV_LO_TAB = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h02, 8'h02, 8'h02,
                                    8'h04, 8'h04, 8'h04, 8'h04, 8'h06, 8'h06, 8'h06, 8'h06};
  localparam tab16_t INV_HI_TAB = '{8'h00, 8'h02, 8'h04, 8'h06, 8'h2c, 8'h2e, 8'h28, 8'h2a,
                                    8'h58, 8'h5a, 8'h5c, 8'h5e, 8'h74, 8'h76, 8'h70, 8'h72};
  localparam tab16_t INV_MULHI_TAB = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h04, 8'h07, 8'h06,
                                       8'h0b, 8'h0a, 8'h09, 8'h08, 8'h0e, 8'h0f, 8'h0c, 8'h0d};

  // Carry-less 8x8 multiply, low byte kept
  function automatic logic [7:0] clmul8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ 8'(a << i);
      end
    end
    return r;
  endfunction

  // Half-fold one 64-bit word as a single 32/32 chunk
  function automatic word_t fold32(input word_t w, input int unsigned k, input logic inv);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = w[31:0];
    hi = w[63:32];
    if (!inv) begin
      hi = hi ^ (hi >> (32 - k));
      lo = lo ^ (hi << k);
    end else begin
      lo = lo ^ (hi << k);
      hi = hi ^ (hi >> (32 - k));
    end
    return {hi, lo};
  endfunction

  // Half-fold both 32-bit chunks of a word as 16/16 pairs
  function automatic word_t fold16(input word_t w, input int unsigned k, input logic inv);
    word_t       r;
    logic [15:0] lo;
    logic [15:0] hi;
    r = '0;
    for (int g = 0; g < 2; g++) begin
      lo = w[32*g +: 16];
      hi = w[32*g+16 +: 16];
      if (!inv) begin
        hi = hi ^ (hi >> (16 - k));
        lo = lo ^ (hi << k);
      end else begin
        lo = lo ^ (hi << k);
        hi = hi ^ (hi >> (16 - k));
      end
      r[32*g +: 16]    = lo;
      r[32*g+16 +: 16] = hi;
    end
    return r;
  endfunction

  // Half-fold a 128-bit chunk; result is {hi, lo}
  function automatic logic [127:0] fold_pair(input word_t lo, input word_t hi,
                                             input int unsigned k, input logic inv);
    word_t l;
    word_t h;
    l = lo;
    h = hi;
    if (!inv) begin
      h = h ^ (h >> (64 - k));
      l = l ^ (h << k);
    end else begin
      l = l ^ (h << k);
      h = h ^ (h >> (64 - k));
    end
    return {h, l};
  endfunction

  // Half-fold the whole 256-bit block
  function automatic blk_t fold_blk(input blk_t b, input int unsigned k, input logic inv);
    blk_t r;
    r = b;
    if (!inv) begin
      r[2] = r[2] ^ (r[3] >> (64 - k));
    end
    r[0] = r[0] ^ (r[2] << k);
    r[1] = r[1] ^ ((r[3] << k) | (r[2] >> (64 - k)));
    if (inv) begin
      r[2] = r[2] ^ (r[3] >> (64 - k));
    end
    return r;
  endfunction

  // Both 128-bit halves of the block
  function automatic blk_t fold_halves(input blk_t b, input int unsigned k, input logic inv);
    blk_t r;
    r = b;
    {r[1], r[0]} = fold_pair(b[0], b[1], k, inv);
    {r[3], r[2]} = fold_pair(b[2], b[3], k, inv);
    return r;
  endfunction

  function automatic blk_t words32(input blk_t b, input int unsigned k, input logic inv);
    blk_t r;
    for (int i = 0; i < 4; i++) begin
      r[i] = fold32(b[i], k, inv);
    end
    return r;
  endfunction

  function automatic blk_t words16(input blk_t b, input int unsigned k, input logic inv);
    blk_t r;
    for (int i = 0; i < 4; i++) begin
      r[i] = fold16(b[i], k, inv);
    end
    return r;
  endfunction

  // Forward byte step on each 16-bit unit
  function automatic blk_t byte_fwd(input blk_t b);
    logic [255:0] v;
    logic [7:0]   l;
    logic [7:0]   h;
    v = b;
    for (int u = 0; u < 16; u++) begin
      l = v[16*u +: 8];
      h = v[16*u+8 +: 8];
      h = h ^ (clmul8(CLMUL_K, {4'h0, h[7:4]}) >> 4);
      l = l ^ clmul8(CLMUL_K, h);
      h = h ^ FWD_HI_TAB[h[7:4]];
      l = l ^ FWD_HI_TAB[l[7:4]];
      h = h ^ FWD_LO_TAB[h[3:0]];
      l = l ^ FWD_LO_TAB[l[3:0]];
      v[16*u +: 8]   = l;
      v[16*u+8 +: 8] = h;
    end
    return blk_t'(v);
  endfunction

  // Inverse byte step: per-byte tables, then per-unit multiply
  function automatic blk_t byte_inv(input blk_t b);
    logic [255:0] v;
    logic [7:0]   x;
    logic [7:0]   l;
    logic [7:0]   h;
    v = b;
    for (int u = 0; u < 32; u++) begin
      x = v[8*u +: 8];
      x = x ^ INV_LO_TAB[x[3:0]];
      x = x ^ INV_HI_TAB[x[7:4]];
      v[8*u +: 8] = x;
    end
    for (int u = 0; u < 16; u++) begin
      l = v[16*u +: 8];
      h = v[16*u+8 +: 8];
      l = l ^ clmul8(CLMUL_K, h);
      h = h ^ INV_MULHI_TAB[h[7:4]];
      v[16*u +: 8]   = l;
      v[16*u+8 +: 8] = h;
    end
    return blk_t'(v);
  endfunction

endpackage

>>> hdl/gpbc_core.sv
module gpbc_core (
  input  logic            mode,
  input  gpbc_pkg::blk_t  blk_in,
  output gpbc_pkg::blk_t  blk_out
);

  gpbc_pkg::blk_t fwd;
  gpbc_pkg::blk_t inv;

  // Forward layer sequence
  always_comb begin
    fwd = gpbc_pkg::fold_blk(blk_in, 8, 1'b0);
    fwd = gpbc_pkg::fold_halves(fwd, 4, 1'b0);
    fwd = gpbc_pkg::words32(fwd, 2, 1'b0);
    fwd = gpbc_pkg::words16(fwd, 1, 1'b0);
    fwd = gpbc_pkg::byte_fwd(fwd);
    fwd = gpbc_pkg::fold_blk(fwd, 32, 1'b0);
    fwd = gpbc_pkg::fold_halves(fwd, 16, 1'b0);
    fwd = gpbc_pkg::words32(fwd, 16, 1'b0);
    fwd[2] = fwd[2] ^ fwd[3];
    fwd[1] = fwd[1] ^ fwd[2];
  end

  // Inverse layer sequence, starting with the inverse byte step
  always_comb begin
    inv = gpbc_pkg::byte_inv(blk_in);
    inv = gpbc_pkg::words32(inv, 16, 1'b1);
    inv[1] = inv[1] ^ inv[2];
    inv[2] = inv[2] ^ inv[3];
    inv = gpbc_pkg::fold_halves(inv, 16, 1'b1);
    inv = gpbc_pkg::fold_blk(inv, 32, 1'b1);
    inv = gpbc_pkg::words16(inv, 1, 1'b1);
    inv = gpbc_pkg::words32(inv, 2, 1'b1);
    inv = gpbc_pkg::fold_halves(inv, 4, 1'b1);
    inv = gpbc_pkg::fold_blk(inv, 8, 1'b1);
  end

  // Select by mode
  always_comb begin
    unique case (gpbc_pkg::mode_t'(mode))
      gpbc_pkg::MODE_FWD: blk_out = fwd;
      gpbc_pkg::MODE_INV: blk_out = inv;
      default:            blk_out = fwd;
    endcase
  end

endmodule

>>> hdl/gf2_poly_basis_convert_256_top.sv
// Basis conversion of one 256-bit binary polynomial over GF(2).
//
// Request channel: drive in_mode, in_word0..in_word3 and in_last_block with
// start high; the request is taken at a rising edge where start is high and
// busy is low. busy is low whenever rst_n is high, so one request can be
// taken on every clock edge.
// Result channel: out_valid is high for exactly one cycle per request, with
// out_out0..out_out3 and out_last_out (copy of in_last_block) valid in that
// cycle. The receiver cannot stall; results must be taken as they appear.
// Path: a taken request is held in the input register, passes the XOR
// network, and its result is held in the result register that drives the
// outputs.
// Throughput: one 256-bit block per cycle, set by the single registered pass
// through the fixed XOR network.
// Reset: rst_n is synchronous and active low; it drops any request in flight
// and holds busy high while asserted. The data registers are not reset.
module gf2_poly_basis_convert_256_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [63:0] in_word0,
  input  logic [63:0] in_word1,
  input  logic [63:0] in_word2,
  input  logic [63:0] in_word3,
  input  logic        in_last_block,
  output logic        out_valid,
  output logic [63:0] out_out0,
  output logic [63:0] out_out1,
  output logic [63:0] out_out2,
  output logic [63:0] out_out3,
  output logic        out_last_out
);

  logic           in_vld_r;
  logic           in_vld_nxt;
  logic           in_mode_r;
  gpbc_pkg::blk_t in_blk_r;
  logic           in_last_r;
  logic           out_vld_r;
  gpbc_pkg::blk_t out_blk_r;
  gpbc_pkg::blk_t out_blk_nxt;
  logic           out_last_r;

  assign busy       = ~rst_n;
  assign in_vld_nxt = start & ~busy;

  // Capture request control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= in_vld_r;
    end
  end

  // Capture request payload
  always_ff @(posedge clk) begin
    if (in_vld_nxt) begin
      in_mode_r <= in_mode;
      in_blk_r  <= {in_word3, in_word2, in_word1, in_word0};
      in_last_r <= in_last_block;
    end
  end

  gpbc_core u_core (
    .mode    (in_mode_r),
    .blk_in  (in_blk_r),
    .blk_out (out_blk_nxt)
  );

  // Hold result for its strobe cycle
  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_blk_r  <= out_blk_nxt;
      out_last_r <= in_last_r;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_out0     = out_blk_r[0];
  assign out_out1     = out_blk_r[1];
  assign out_out2     = out_blk_r[2];
  assign out_out3     = out_blk_r[3];
  assign out_last_out = out_last_r;

endmodule

>>> hdl/gpbc_chk.sv
`include "gf2_poly_basis_convert_256_top_assert.svh"

module gpbc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [63:0] in_word0,
  input logic [63:0] in_word1,
  input logic [63:0] in_word2,
  input logic [63:0] in_word3,
  input logic        in_last_block,
  input logic        out_valid,
  input logic [63:0] out_out0,
  input logic [63:0] out_out1,
  input logic [63:0] out_out2,
  input logic [63:0] out_out3,
  input logic        out_last_out
);

  logic req;
  logic zero_in;
  logic zero_out;

  assign req      = start && !busy;
  assign zero_in  = (in_word0 == '0) && (in_word1 == '0) && (in_word2 == '0) && (in_word3 == '0);
  assign zero_out = (out_out0 == '0) && (out_out1 == '0) && (out_out2 == '0) && (out_out3 == '0);

  // Full rate: never busy out of reset
  `GPBC_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy, "busy high out of reset")

  // Every request yields a result
  `GPBC_ASSERT_NXT(a_req_result, clk, rst_n, req, ##1 out_valid, "request without result")

  // No result without an earlier request
  `GPBC_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, $past(req, 2), "result without request")

  // Last flag travels with its block
  `GPBC_ASSERT_IMP(a_last_follow, clk, rst_n, out_valid, out_last_out == $past(in_last_block, 2), "last flag mismatch")

  // Linear map: zero block converts to zero block
  `GPBC_ASSERT_IMP(a_zero_map, clk, rst_n, out_valid && $past(zero_in, 2), zero_out, "zero block not mapped to zero")

endmodule

bind gf2_poly_basis_convert_256_top gpbc_chk u_gpbc_chk (.*);
